// ===== hw/rtl/rrps_pkg.sv =====
// Shared types, field codes and constants of the round-robin process scheduler.
package rrps_pkg;

  localparam int TIME_W = 24;
  localparam int VAL_W  = 16;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [VAL_W-1:0]  val_t;

  // input word modes
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_STEP  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  // result status codes
  localparam logic [2:0] STAT_LOADED     = 3'd0;
  localparam logic [2:0] STAT_REJECTED   = 3'd1;
  localparam logic [2:0] STAT_DISPATCHED = 3'd2;
  localparam logic [2:0] STAT_ALL_DONE   = 3'd3;
  localparam logic [2:0] STAT_CLEARED    = 3'd4;

  localparam val_t  QUANTUM_RESET = 16'd4;
  localparam time_t TIME_SAT      = 24'hFFFFFF;

endpackage

// ===== hw/rtl/rrps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rrps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/round_robin_process_scheduler.sv =====
// Top level of the round-robin process scheduler: sequencer, tables and ready queue.
//
//   channel | ports                          | handshake
//   --------+--------------------------------+-------------------------------------
//   input   | in_mode, in_arrival_time,      | taken when start=1 and busy=0
//           | in_burst_time                  |
//   result  | out_status ... out_waiting_time| out_valid high for one cycle
//   config  | cfg_time_quantum               | written when cfg_valid & cfg_ready
//
// Clear, reject, mode three and a step with all processes done are handled in idle.
// Load: insertion walks up the sorted list, one registered RAM read and one compare
// per later arrival that it shifts; at the list head it writes the slot with no read.
// Step: admission pass (read, compare per entry), queue read, process read, run,
// second pass, result (via S_FIN if it finishes); an idle jump adds a pass.
// Reset clears state but not the RAMs; the receiver cannot stall, busy holds off new words.
module round_robin_process_scheduler
  import rrps_pkg::*;
#(
  parameter int MAX_PROCS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_arrival_time,
  input  logic [15:0] in_burst_time,
  // result channel
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [3:0]  out_process_index,
  output logic [23:0] out_segment_start,
  output logic [23:0] out_segment_end,
  output logic        out_finished,
  output logic [23:0] out_completion_time,
  output logic [23:0] out_turnaround_time,
  output logic [23:0] out_waiting_time,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_time_quantum
);

  localparam int IW = $clog2(MAX_PROCS);       // process index width
  localparam int CW = $clog2(MAX_PROCS + 1);   // count width
  localparam int SW = VAL_W + IW;              // sorted list entry {arrival, index}
  localparam int PW = 3 * VAL_W;               // process entry {arrival, burst, remaining}

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;
  localparam logic [3:0] S_INS_CMP = 4'd2;
  localparam logic [3:0] S_ADM_RD  = 4'd3;
  localparam logic [3:0] S_ADM_CMP = 4'd4;
  localparam logic [3:0] S_ADM_END = 4'd5;
  localparam logic [3:0] S_Q_RD    = 4'd6;
  localparam logic [3:0] S_Q_WAIT  = 4'd7;
  localparam logic [3:0] S_P_WAIT  = 4'd8;
  localparam logic [3:0] S_RUN     = 4'd9;
  localparam logic [3:0] S_POST    = 4'd10;
  localparam logic [3:0] S_FIN     = 4'd11;

  // admission pass that is running
  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_JUMP  = 2'd1;
  localparam logic [1:0] PH_POST  = 2'd2;

  // control state
  logic [3:0]    state_r, state_nxt;
  logic [1:0]    phase_r, phase_nxt;
  val_t          quantum_r, quantum_nxt;
  time_t         time_r, time_nxt;
  logic [CW-1:0] pc_r, pc_nxt;          // processes loaded
  logic [CW-1:0] done_r, done_nxt;      // processes finished
  logic [CW-1:0] ptr_r, ptr_nxt;        // sorted list entries admitted so far
  logic [CW-1:0] qcount_r, qcount_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic          run_started_r, run_started_nxt;
  logic          out_valid_r, out_valid_nxt;

  // working payload
  logic [CW-1:0] j_r, j_nxt;            // insertion slot
  val_t          new_arr_r, new_arr_nxt;
  val_t          pend_arr_r, pend_arr_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  val_t          arr_r, arr_nxt;
  val_t          bur_r, bur_nxt;
  val_t          rem_r, rem_nxt;
  val_t          run_r, run_nxt;
  time_t         start_r, start_nxt;
  time_t         tat_r, tat_nxt;

  // result registers
  logic [2:0]    out_status_r, out_status_nxt;
  logic [3:0]    out_index_r, out_index_nxt;
  time_t         out_seg_start_r, out_seg_start_nxt;
  time_t         out_seg_end_r, out_seg_end_nxt;
  logic          out_finished_r, out_finished_nxt;
  time_t         out_compl_r, out_compl_nxt;
  time_t         out_tat_r, out_tat_nxt;
  time_t         out_wt_r, out_wt_nxt;

  // RAM ports
  logic          srt_we, srt_re;
  logic [IW-1:0] srt_waddr, srt_raddr;
  logic [SW-1:0] srt_wdata, srt_rdata;
  logic          prc_we, prc_re;
  logic [IW-1:0] prc_waddr, prc_raddr;
  logic [PW-1:0] prc_wdata, prc_rdata;
  logic          que_we, que_re;
  logic [IW-1:0] que_waddr, que_raddr;
  logic [IW-1:0] que_wdata, que_rdata;

  // decoded read data and shared arithmetic
  val_t          srt_rd_arr;
  logic [IW-1:0] srt_rd_idx;
  val_t          prc_rd_arr, prc_rd_bur, prc_rd_rem;
  val_t          q_eff;
  val_t          run_sel;
  logic [TIME_W:0] time_sum;
  time_t         time_after;
  val_t          rem_left;
  time_t         tat_calc, wt_calc;
  logic [CW-1:0] j_prev;
  logic [CW+3:0] pc_ext;
  logic [IW+3:0] idx_ext;
  logic [IW-1:0] head_inc, tail_inc;

  // sorted list by (arrival, load index): admitted processes always form its prefix
  rrps_ram #(.WIDTH(SW), .DEPTH(MAX_PROCS)) u_sorted (
    .clk   (clk),
    .we    (srt_we),
    .waddr (srt_waddr),
    .wdata (srt_wdata),
    .re    (srt_re),
    .raddr (srt_raddr),
    .rdata (srt_rdata)
  );

  // process table indexed by load order
  rrps_ram #(.WIDTH(PW), .DEPTH(MAX_PROCS)) u_procs (
    .clk   (clk),
    .we    (prc_we),
    .waddr (prc_waddr),
    .wdata (prc_wdata),
    .re    (prc_re),
    .raddr (prc_raddr),
    .rdata (prc_rdata)
  );

  // circular ready queue of process indexes
  rrps_ram #(.WIDTH(IW), .DEPTH(MAX_PROCS)) u_queue (
    .clk   (clk),
    .we    (que_we),
    .waddr (que_waddr),
    .wdata (que_wdata),
    .re    (que_re),
    .raddr (que_raddr),
    .rdata (que_rdata)
  );

  assign srt_rd_arr = srt_rdata[SW-1:IW];
  assign srt_rd_idx = srt_rdata[IW-1:0];
  assign prc_rd_arr = prc_rdata[PW-1:2*VAL_W];
  assign prc_rd_bur = prc_rdata[2*VAL_W-1:VAL_W];
  assign prc_rd_rem = prc_rdata[VAL_W-1:0];

  // a zero quantum runs as one
  assign q_eff   = (quantum_r == '0) ? val_t'(1) : quantum_r;
  assign run_sel = (prc_rd_rem < q_eff) ? prc_rd_rem : q_eff;

  // advance time by the slice, saturating at the top of the time range
  assign time_sum   = (TIME_W+1)'(time_r) + (TIME_W+1)'(run_r);
  assign time_after = time_sum[TIME_W] ? TIME_SAT : time_sum[TIME_W-1:0];
  assign rem_left   = rem_r - run_r;

  assign tat_calc = (time_r >= time_t'(arr_r)) ? time_r - time_t'(arr_r) : '0;
  assign wt_calc  = (tat_r >= time_t'(bur_r)) ? tat_r - time_t'(bur_r) : '0;

  assign j_prev   = j_r - 1'b1;
  assign pc_ext   = {4'd0, pc_r};
  assign idx_ext  = {4'd0, idx_r};
  assign head_inc = (head_r == IW'(MAX_PROCS - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == IW'(MAX_PROCS - 1)) ? '0 : tail_r + 1'b1;

  always_comb begin
    state_nxt       = state_r;
    phase_nxt       = phase_r;
    quantum_nxt     = quantum_r;
    time_nxt        = time_r;
    pc_nxt          = pc_r;
    done_nxt        = done_r;
    ptr_nxt         = ptr_r;
    qcount_nxt      = qcount_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    run_started_nxt = run_started_r;
    j_nxt           = j_r;
    new_arr_nxt     = new_arr_r;
    pend_arr_nxt    = pend_arr_r;
    idx_nxt         = idx_r;
    arr_nxt         = arr_r;
    bur_nxt         = bur_r;
    rem_nxt         = rem_r;
    run_nxt         = run_r;
    start_nxt       = start_r;
    tat_nxt         = tat_r;

    // result fields mean something only under the strobe; zero them otherwise
    out_valid_nxt     = 1'b0;
    out_status_nxt    = '0;
    out_index_nxt     = '0;
    out_seg_start_nxt = '0;
    out_seg_end_nxt   = '0;
    out_finished_nxt  = 1'b0;
    out_compl_nxt     = '0;
    out_tat_nxt       = '0;
    out_wt_nxt        = '0;

    srt_we    = 1'b0;
    srt_waddr = '0;
    srt_wdata = '0;
    srt_re    = 1'b0;
    srt_raddr = '0;
    prc_we    = 1'b0;
    prc_waddr = '0;
    prc_wdata = '0;
    prc_re    = 1'b0;
    prc_raddr = '0;
    que_we    = 1'b0;
    que_waddr = '0;
    que_wdata = '0;
    que_re    = 1'b0;
    que_raddr = '0;

    if (cfg_valid) begin
      quantum_nxt = cfg_time_quantum;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_mode)
            MODE_LOAD: begin
              if (run_started_r || pc_r >= CW'(MAX_PROCS)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_REJECTED;
              end else begin
                // store the process, then insert it into the sorted list
                prc_we      = 1'b1;
                prc_waddr   = pc_r[IW-1:0];
                prc_wdata   = {in_arrival_time, in_burst_time, in_burst_time};
                new_arr_nxt = in_arrival_time;
                j_nxt       = pc_r;
                state_nxt   = S_INS_RD;
              end
            end
            MODE_STEP: begin
              run_started_nxt = 1'b1;
              if (done_r >= pc_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_ALL_DONE;
              end else begin
                phase_nxt = PH_FIRST;
                state_nxt = S_ADM_RD;
              end
            end
            MODE_CLEAR: begin
              pc_nxt          = '0;
              done_nxt        = '0;
              ptr_nxt         = '0;
              qcount_nxt      = '0;
              head_nxt        = '0;
              tail_nxt        = '0;
              time_nxt        = '0;
              run_started_nxt = 1'b0;
              out_valid_nxt   = 1'b1;
              out_status_nxt  = STAT_CLEARED;
            end
            default: begin
              // mode three: drop the word
            end
          endcase
        end
      end

      S_INS_RD: begin
        if (j_r == '0) begin
          srt_we         = 1'b1;
          srt_waddr      = '0;
          srt_wdata      = {new_arr_r, pc_r[IW-1:0]};
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_LOADED;
          out_index_nxt  = pc_ext[3:0];
          pc_nxt         = pc_r + 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          srt_re    = 1'b1;
          srt_raddr = j_prev[IW-1:0];
          state_nxt = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        srt_we    = 1'b1;
        srt_waddr = j_r[IW-1:0];
        if (srt_rd_arr > new_arr_r) begin
          // shift the later arrival down one slot and keep walking up
          srt_wdata = srt_rdata;
          j_nxt     = j_prev;
          state_nxt = S_INS_RD;
        end else begin
          // equal arrivals stay in load order
          srt_wdata      = {new_arr_r, pc_r[IW-1:0]};
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_LOADED;
          out_index_nxt  = pc_ext[3:0];
          pc_nxt         = pc_r + 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_ADM_RD: begin
        if (ptr_r < pc_r) begin
          srt_re    = 1'b1;
          srt_raddr = ptr_r[IW-1:0];
          state_nxt = S_ADM_CMP;
        end else begin
          state_nxt = S_ADM_END;
        end
      end

      S_ADM_CMP: begin
        if (time_t'(srt_rd_arr) <= time_r) begin
          que_we     = 1'b1;
          que_waddr  = tail_r;
          que_wdata  = srt_rd_idx;
          tail_nxt   = tail_inc;
          qcount_nxt = qcount_r + 1'b1;
          ptr_nxt    = ptr_r + 1'b1;
          state_nxt  = S_ADM_RD;
        end else begin
          // hold the earliest pending arrival for an idle jump
          pend_arr_nxt = srt_rd_arr;
          state_nxt    = S_ADM_END;
        end
      end

      S_ADM_END: begin
        case (phase_r)
          PH_FIRST: begin
            if (qcount_r != '0) begin
              state_nxt = S_Q_RD;
            end else if (ptr_r < pc_r) begin
              // queue empty: jump time to the next arrival and admit again
              if (time_t'(pend_arr_r) > time_r) begin
                time_nxt = time_t'(pend_arr_r);
              end
              phase_nxt = PH_JUMP;
              state_nxt = S_ADM_RD;
            end else begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_ALL_DONE;
              state_nxt      = S_IDLE;
            end
          end
          PH_JUMP: begin
            if (qcount_r != '0) begin
              state_nxt = S_Q_RD;
            end else begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_ALL_DONE;
              state_nxt      = S_IDLE;
            end
          end
          default: begin
            state_nxt = S_POST;
          end
        endcase
      end

      S_Q_RD: begin
        que_re    = 1'b1;
        que_raddr = head_r;
        state_nxt = S_Q_WAIT;
      end

      S_Q_WAIT: begin
        idx_nxt   = que_rdata;
        prc_re    = 1'b1;
        prc_raddr = que_rdata;
        state_nxt = S_P_WAIT;
      end

      S_P_WAIT: begin
        arr_nxt   = prc_rd_arr;
        bur_nxt   = prc_rd_bur;
        rem_nxt   = prc_rd_rem;
        run_nxt   = run_sel;
        state_nxt = S_RUN;
      end

      S_RUN: begin
        // pop the head, charge the slice and write back what is left
        prc_we     = 1'b1;
        prc_waddr  = idx_r;
        prc_wdata  = {arr_r, bur_r, rem_left};
        rem_nxt    = rem_left;
        start_nxt  = time_r;
        time_nxt   = time_after;
        head_nxt   = head_inc;
        qcount_nxt = qcount_r - 1'b1;
        phase_nxt  = PH_POST;
        state_nxt  = S_ADM_RD;
      end

      S_POST: begin
        if (rem_r != '0) begin
          // preempted: back to the tail behind the new arrivals
          que_we            = 1'b1;
          que_waddr         = tail_r;
          que_wdata         = idx_r;
          tail_nxt          = tail_inc;
          qcount_nxt        = qcount_r + 1'b1;
          out_valid_nxt     = 1'b1;
          out_status_nxt    = STAT_DISPATCHED;
          out_index_nxt     = idx_ext[3:0];
          out_seg_start_nxt = start_r;
          out_seg_end_nxt   = time_r;
          state_nxt         = S_IDLE;
        end else begin
          done_nxt  = done_r + 1'b1;
          tat_nxt   = tat_calc;
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        out_valid_nxt     = 1'b1;
        out_status_nxt    = STAT_DISPATCHED;
        out_index_nxt     = idx_ext[3:0];
        out_seg_start_nxt = start_r;
        out_seg_end_nxt   = time_r;
        out_finished_nxt  = 1'b1;
        out_compl_nxt     = time_r;
        out_tat_nxt       = tat_r;
        out_wt_nxt        = wt_calc;
        state_nxt         = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      phase_r       <= PH_FIRST;
      quantum_r     <= QUANTUM_RESET;
      time_r        <= '0;
      pc_r          <= '0;
      done_r        <= '0;
      ptr_r         <= '0;
      qcount_r      <= '0;
      head_r        <= '0;
      tail_r        <= '0;
      run_started_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      phase_r       <= phase_nxt;
      quantum_r     <= quantum_nxt;
      time_r        <= time_nxt;
      pc_r          <= pc_nxt;
      done_r        <= done_nxt;
      ptr_r         <= ptr_nxt;
      qcount_r      <= qcount_nxt;
      head_r        <= head_nxt;
      tail_r        <= tail_nxt;
      run_started_r <= run_started_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    j_r             <= j_nxt;
    new_arr_r       <= new_arr_nxt;
    pend_arr_r      <= pend_arr_nxt;
    idx_r           <= idx_nxt;
    arr_r           <= arr_nxt;
    bur_r           <= bur_nxt;
    rem_r           <= rem_nxt;
    run_r           <= run_nxt;
    start_r         <= start_nxt;
    tat_r           <= tat_nxt;
    out_status_r    <= out_status_nxt;
    out_index_r     <= out_index_nxt;
    out_seg_start_r <= out_seg_start_nxt;
    out_seg_end_r   <= out_seg_end_nxt;
    out_finished_r  <= out_finished_nxt;
    out_compl_r     <= out_compl_nxt;
    out_tat_r       <= out_tat_nxt;
    out_wt_r        <= out_wt_nxt;
  end

  assign busy                = (state_r != S_IDLE);
  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_process_index   = out_index_r;
  assign out_segment_start   = out_seg_start_r;
  assign out_segment_end     = out_seg_end_r;
  assign out_finished        = out_finished_r;
  assign out_completion_time = out_compl_r;
  assign out_turnaround_time = out_tat_r;
  assign out_waiting_time    = out_wt_r;

endmodule

// ===== tb/sv/round_robin_process_scheduler_tb.sv =====
// Self-checking testbench of the round-robin process scheduler, with a predictor and idle bursts.
`timescale 1ns / 1ps

module round_robin_process_scheduler_tb
  import rrps_pkg::*;
();

  localparam int NPROC          = 16;
  localparam int N_RANDOM       = 850;   // random words to send after the directed table
  localparam int QUIET_TAIL     = 120;   // last words of the run go out with no idling
  localparam int SETTLE         = 120;   // longest step plus margin, used before cfg writes and at the end
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all before giving up
  localparam int EXP_DEPTH      = 16;    // expected result words held at most

  // One result word, in port order.
  typedef struct packed {
    logic [2:0] status;
    logic [3:0] pidx;
    time_t      seg_start;
    time_t      seg_end;
    logic       fin;
    time_t      done_at;
    time_t      turnaround;
    time_t      waiting;
  } sched_res_t;

  // A directed row either sends one word or rewrites the quantum (value in arr).
  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [1:0] mode;
    val_t       arr;
    val_t       bur;
    logic       pinned;  // expectation typed in below instead of predicted
    sched_res_t res;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_mode = MODE_NOP;
  logic [15:0] in_arrival_time = '0;
  logic [15:0] in_burst_time = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [3:0]  out_process_index;
  logic [23:0] out_segment_start;
  logic [23:0] out_segment_end;
  logic        out_finished;
  logic [23:0] out_completion_time;
  logic [23:0] out_turnaround_time;
  logic [23:0] out_waiting_time;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_time_quantum = '0;

  round_robin_process_scheduler #(.MAX_PROCS(NPROC)) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_mode             (in_mode),
    .in_arrival_time     (in_arrival_time),
    .in_burst_time       (in_burst_time),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_process_index   (out_process_index),
    .out_segment_start   (out_segment_start),
    .out_segment_end     (out_segment_end),
    .out_finished        (out_finished),
    .out_completion_time (out_completion_time),
    .out_turnaround_time (out_turnaround_time),
    .out_waiting_time    (out_waiting_time),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_time_quantum    (cfg_time_quantum)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scheduler predictor: a private copy of the process table, the ready ring,
  // the clock of the schedule and the quantum register.
  // ---------------------------------------------------------------------------
  val_t        arr_tab   [NPROC];
  val_t        burst_tab [NPROC];
  val_t        left_tab  [NPROC];
  bit          admitted  [NPROC];
  logic [3:0]  ready_ring[NPROC];
  int unsigned ring_head, ring_cnt, loaded_cnt, retired_cnt, now_t;
  bit          run_started;
  val_t        quantum_q = QUANTUM_RESET;

  sched_res_t  exp_ring [EXP_DEPTH];   // expected result words, oldest at exp_rd
  int unsigned exp_wr = 0;
  int unsigned exp_rd = 0;
  int unsigned sent_cnt = 0;     // words sent that must produce a result
  int unsigned seen_cnt = 0;     // result words observed
  int unsigned error_cnt = 0;
  int unsigned quiet_cycles = 0;

  // Stimulus side: typed-in expectation travels with the word it belongs to.
  logic        pin_on = 1'b0;
  sched_res_t  pin_res = '0;
  bit          idle_on = 1'b1;
  val_t        quantum_set = QUANTUM_RESET;

  function automatic void clear_schedule();
    foreach (admitted[i]) begin
      admitted[i] = 1'b0;
    end
    ring_head   = 0;
    ring_cnt    = 0;
    loaded_cnt  = 0;
    retired_cnt = 0;
    now_t       = 0;
    run_started = 1'b0;
  endfunction

  function automatic void ring_push(input int unsigned idx);
    if (ring_cnt >= NPROC) return;
    ready_ring[(ring_head + ring_cnt) % NPROC] = idx[3:0];
    ring_cnt++;
  endfunction

  // Hold one expected result word until its result shows up.
  function automatic void exp_store(input sched_res_t r);
    exp_ring[exp_wr % EXP_DEPTH] = r;
    exp_wr++;
  endfunction

  // Admit every arrived process: earliest arrival first, ties in load order.
  function automatic void admit_arrived();
    int pick;
    do begin
      pick = -1;
      for (int i = 0; i < loaded_cnt; i++) begin
        if (!admitted[i] && arr_tab[i] <= now_t &&
            (pick < 0 || arr_tab[i] < arr_tab[pick])) begin
          pick = i;
        end
      end
      if (pick >= 0) begin
        admitted[pick] = 1'b1;
        ring_push(pick);
      end
    end while (pick >= 0);
  endfunction

  // Advance the schedule by one input word; return 1 when it yields a result word.
  function automatic bit predict_word(input logic [1:0] mode, input val_t arr, input val_t bur,
                                      output sched_res_t res);
    int unsigned next_arr, q, slice, idx, begin_t, tat, wt;
    bit          pending;
    res = '0;
    case (mode)
      MODE_NOP: begin
        return 1'b0;
      end
      MODE_CLEAR: begin
        clear_schedule();
        res.status = STAT_CLEARED;
      end
      MODE_LOAD: begin
        if (run_started || loaded_cnt >= NPROC) begin
          res.status = STAT_REJECTED;
        end else begin
          arr_tab[loaded_cnt]   = arr;
          burst_tab[loaded_cnt] = bur;
          left_tab[loaded_cnt]  = bur;
          admitted[loaded_cnt]  = 1'b0;
          res.status = STAT_LOADED;
          res.pidx   = loaded_cnt[3:0];
          loaded_cnt++;
        end
      end
      default: begin
        run_started = 1'b1;
        if (retired_cnt >= loaded_cnt) begin
          res.status = STAT_ALL_DONE;
          return 1'b1;
        end
        admit_arrived();
        // Ring empty: jump the clock to the earliest pending arrival.
        if (ring_cnt == 0) begin
          pending  = 1'b0;
          next_arr = 0;
          for (int i = 0; i < loaded_cnt; i++) begin
            if (!admitted[i] && (!pending || arr_tab[i] < next_arr)) begin
              next_arr = arr_tab[i];
              pending  = 1'b1;
            end
          end
          if (pending && next_arr > now_t) now_t = next_arr;
          admit_arrived();
          if (ring_cnt == 0) begin
            res.status = STAT_ALL_DONE;
            return 1'b1;
          end
        end
        idx       = ready_ring[ring_head];
        q         = (quantum_q == 0) ? 1 : quantum_q;
        slice     = (left_tab[idx] < q) ? left_tab[idx] : q;
        begin_t   = now_t;
        ring_head = (ring_head + 1) % NPROC;
        ring_cnt--;
        left_tab[idx] = val_t'(left_tab[idx] - slice);
        now_t = (now_t + slice > TIME_SAT) ? TIME_SAT : now_t + slice;
        // Newcomers of this slice go ahead of the preempted process.
        admit_arrived();
        res.status    = STAT_DISPATCHED;
        res.pidx      = idx[3:0];
        res.seg_start = begin_t[23:0];
        res.seg_end   = now_t[23:0];
        if (left_tab[idx] > 0) begin
          ring_push(idx);
        end else begin
          tat = (now_t >= arr_tab[idx]) ? now_t - arr_tab[idx] : 0;
          wt  = (tat >= burst_tab[idx]) ? tat - burst_tab[idx] : 0;
          retired_cnt++;
          res.fin        = 1'b1;
          res.done_at    = now_t[23:0];
          res.turnaround = tat[23:0];
          res.waiting    = wt[23:0];
        end
      end
    endcase
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic flag_error(input string msg);
    error_cnt++;
    $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [23:0] got, input logic [23:0] want);
    if (got !== want) flag_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // Sample everything at the rising edge, before the block's own updates land:
  // first retire a result word, then predict the word taken at this edge,
  // then track the quantum register, and last run the watchdog.
  always @(posedge clk) begin : monitor
    sched_res_t got, want, calc;
    bit         makes;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        seen_cnt++;
        got = {out_status, out_process_index, out_segment_start, out_segment_end,
               out_finished, out_completion_time, out_turnaround_time, out_waiting_time};
        if (exp_wr == exp_rd) begin
          flag_error($sformatf("result word with status %0d and none expected", out_status));
        end else begin
          want = exp_ring[exp_rd % EXP_DEPTH];
          exp_rd++;
          check_field("status", 24'(got.status), 24'(want.status));
          check_field("process_index", 24'(got.pidx), 24'(want.pidx));
          check_field("segment_start", got.seg_start, want.seg_start);
          check_field("segment_end", got.seg_end, want.seg_end);
          check_field("finished", 24'(got.fin), 24'(want.fin));
          check_field("completion_time", got.done_at, want.done_at);
          check_field("turnaround_time", got.turnaround, want.turnaround);
          check_field("waiting_time", got.waiting, want.waiting);
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        makes = predict_word(in_mode, in_arrival_time, in_burst_time, calc);
        if (makes) exp_store(pin_on ? pin_res : calc);
      end
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) quantum_q = cfg_time_quantum;
      if (out_valid === 1'b1 || (start === 1'b1 && busy === 1'b0) ||
          (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
        quiet_cycles = 0;
      end else if (++quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Send one word: maybe idle first, then hold start until the block takes it.
  // start is left high; the next call or the caller decides what comes after.
  task automatic send_word(input logic [1:0] mode, input val_t arr, input val_t bur,
                           input bit pinned, input sched_res_t res);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    start           <= 1'b1;
    in_mode         <= mode;
    in_arrival_time <= arr;
    in_burst_time   <= bur;
    pin_on          <= pinned;
    pin_res         <= res;
    do @(posedge clk); while (busy !== 1'b0);
    if (mode != MODE_NOP) sent_cnt++;
  endtask

  task automatic send_plain(input logic [1:0] mode, input val_t arr, input val_t bur);
    send_word(mode, arr, bur, 1'b0, '0);
  endtask

  // Rewrite the quantum only with the block idle: drain results, then let a
  // possible trailing no-op or long step settle.
  task automatic write_quantum(input val_t q);
    start <= 1'b0;
    while (seen_cnt < sent_cnt) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid        <= 1'b1;
    cfg_time_quantum <= q;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid   <= 1'b0;
    quantum_set = q;
  endtask

  function automatic sched_res_t res_of(input logic [2:0] st, input logic [3:0] idx,
                                        input time_t s, input time_t e, input logic fin,
                                        input time_t d, input time_t t, input time_t w);
    return {st, idx, s, e, fin, d, t, w};
  endfunction

  function automatic plan_row_t word_row(input logic [1:0] mode, input val_t arr, input val_t bur);
    return {ROW_WORD, mode, arr, bur, 1'b0, sched_res_t'('0)};
  endfunction

  function automatic plan_row_t pin_row(input logic [1:0] mode, input val_t arr, input val_t bur,
                                        input sched_res_t res);
    return {ROW_WORD, mode, arr, bur, 1'b1, res};
  endfunction

  function automatic plan_row_t cfg_row(input val_t q);
    return {ROW_CFG, MODE_NOP, q, 16'd0, 1'b0, sched_res_t'('0)};
  endfunction

  // One well-formed job set: clear, load a batch, then step it to the end.
  // Noise: ignored words, loads after the run has started, loads past a full
  // table, and now and then a run cut short by the next clear.
  task automatic run_job_set();
    int unsigned q_eff, cap, nproc, spread, dispatches, nsteps;
    val_t        arr, bur;
    q_eff = (quantum_set == 0) ? 1 : quantum_set;
    cap   = (4 * q_eff > 65535) ? 65535 : 4 * q_eff;
    case ($urandom_range(0, 9))
      0:       nproc = 0;
      1, 2:    nproc = $urandom_range(14, 18);
      default: nproc = $urandom_range(1, 8);
    endcase
    case ($urandom_range(0, 3))
      0:       spread = 0;
      1:       spread = 20;
      2:       spread = 300;
      default: spread = 65535;
    endcase
    send_plain(MODE_CLEAR, val_t'($urandom), val_t'($urandom));
    dispatches = 0;
    for (int p = 0; p < nproc; p++) begin
      arr = val_t'($urandom_range(0, spread));
      bur = val_t'($urandom_range(0, cap));
      send_plain(MODE_LOAD, arr, bur);
      // a zero burst still takes one dispatch
      if (p < NPROC) dispatches += (bur == 0) ? 1 : (bur + q_eff - 1) / q_eff;
      if ($urandom_range(0, 19) == 0) send_plain(MODE_NOP, val_t'($urandom), val_t'($urandom));
    end
    nsteps = dispatches + $urandom_range(1, 2);
    if ($urandom_range(0, 9) == 0) nsteps = $urandom_range(0, nsteps);
    for (int s = 0; s < nsteps; s++) begin
      send_plain(MODE_STEP, val_t'($urandom), val_t'($urandom));
      case ($urandom_range(0, 29))
        0:       send_plain(MODE_LOAD, val_t'($urandom), val_t'($urandom));
        1:       send_plain(MODE_NOP, val_t'($urandom), val_t'($urandom));
        default: ;
      endcase
    end
  endtask

  plan_row_t plan [24];

  initial begin : driver
    int unsigned rand_goal;
    val_t        q;
    clear_schedule();

    // Directed table. Phase one runs at the reset quantum of 4: a step and a
    // load before anything is loaded, a clear, an ignored word, a tie on
    // arrival, a zero burst, an idle jump and a load after the run started.
    // Phase two drops the quantum to zero, which acts as one. Phase three uses
    // the largest quantum with the latest arrival and the longest burst.
    plan = '{
      pin_row(MODE_STEP, 16'd0, 16'd0, res_of(STAT_ALL_DONE, 0, 0, 0, 0, 0, 0, 0)),
      pin_row(MODE_LOAD, 16'd5, 16'd5, res_of(STAT_REJECTED, 0, 0, 0, 0, 0, 0, 0)),
      pin_row(MODE_CLEAR, 16'd0, 16'd0, res_of(STAT_CLEARED, 0, 0, 0, 0, 0, 0, 0)),
      word_row(MODE_NOP, 16'hFFFF, 16'hFFFF),
      pin_row(MODE_LOAD, 16'd0, 16'd0, res_of(STAT_LOADED, 0, 0, 0, 0, 0, 0, 0)),
      pin_row(MODE_LOAD, 16'd3, 16'd10, res_of(STAT_LOADED, 1, 0, 0, 0, 0, 0, 0)),
      pin_row(MODE_LOAD, 16'd3, 16'd1, res_of(STAT_LOADED, 2, 0, 0, 0, 0, 0, 0)),
      pin_row(MODE_LOAD, 16'd1, 16'd4, res_of(STAT_LOADED, 3, 0, 0, 0, 0, 0, 0)),
      pin_row(MODE_STEP, 16'd0, 16'd0, res_of(STAT_DISPATCHED, 0, 0, 0, 1, 0, 0, 0)),
      word_row(MODE_STEP, 16'd0, 16'd0),
      word_row(MODE_STEP, 16'd0, 16'd0),
      word_row(MODE_STEP, 16'd0, 16'd0),
      word_row(MODE_STEP, 16'd0, 16'd0),
      pin_row(MODE_LOAD, 16'd0, 16'd1, res_of(STAT_REJECTED, 0, 0, 0, 0, 0, 0, 0)),
      cfg_row(16'd0),
      word_row(MODE_STEP, 16'd0, 16'd0),
      word_row(MODE_STEP, 16'd0, 16'd0),
      cfg_row(16'hFFFF),
      pin_row(MODE_CLEAR, 16'd0, 16'd0, res_of(STAT_CLEARED, 0, 0, 0, 0, 0, 0, 0)),
      pin_row(MODE_LOAD, 16'hFFFF, 16'hFFFF, res_of(STAT_LOADED, 0, 0, 0, 0, 0, 0, 0)),
      pin_row(MODE_LOAD, 16'hFFFF, 16'd0, res_of(STAT_LOADED, 1, 0, 0, 0, 0, 0, 0)),
      pin_row(MODE_STEP, 16'd0, 16'd0, res_of(STAT_DISPATCHED, 0, 24'h00FFFF, 24'h01FFFE, 1,
                                              24'h01FFFE, 24'h00FFFF, 24'h0)),
      pin_row(MODE_STEP, 16'd0, 16'd0, res_of(STAT_DISPATCHED, 1, 24'h01FFFE, 24'h01FFFE, 1,
                                              24'h01FFFE, 24'h00FFFF, 24'h00FFFF)),
      pin_row(MODE_STEP, 16'd0, 16'd0, res_of(STAT_ALL_DONE, 0, 0, 0, 0, 0, 0, 0))
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) write_quantum(plan[r].arr);
      else send_word(plan[r].mode, plan[r].arr, plan[r].bur, plan[r].pinned, plan[r].res);
    end

    // Random job sets, retuning the quantum now and then; extremes often.
    rand_goal = sent_cnt + N_RANDOM;
    while (sent_cnt < rand_goal) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 5))
          0:       q = 16'd1;
          1:       q = 16'hFFFF;
          2:       q = 16'd0;
          3:       q = val_t'($urandom_range(2, 8));
          4:       q = val_t'($urandom);
          default: q = val_t'($urandom_range(1, 30));
        endcase
        write_quantum(q);
      end
      // hold the tail of the run free of idling; leave some sets gap-free too
      idle_on = (sent_cnt + QUIET_TAIL < rand_goal) && ($urandom_range(0, 4) != 0);
      run_job_set();
    end

    // Drain, let the block settle, then judge.
    start <= 1'b0;
    while (seen_cnt < sent_cnt) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (exp_wr != exp_rd) begin
      flag_error($sformatf("%0d expected result words never arrived", exp_wr - exp_rd));
    end
    if (error_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
